>>> sv/csi_escape_sequence_parser_macros.svh
// Assertion macros used by the CSI parser checker.
`ifndef CSI_ESCAPE_SEQUENCE_PARSER_MACROS_SVH
`define CSI_ESCAPE_SEQUENCE_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define CSI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("csi check failed");

// Next-cycle implication, sampled on clk_i, off while in reset.
`define CSI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("csi check failed");

`endif

>>> sv/csi_pkg.sv
// Types and constants of the CSI escape sequence parser.
package csi_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ParamW = 16;
  localparam int unsigned RowW   = 8;
  localparam int unsigned EventW = 3;

  localparam logic [ByteW-1:0] ChEsc     = 8'h1B;
  localparam logic [ByteW-1:0] ChBracket = 8'h5B;  // '['
  localparam logic [ByteW-1:0] ChDown    = 8'h42;  // 'B'
  localparam logic [ByteW-1:0] ChClear   = 8'h4A;  // 'J'
  localparam logic [ByteW-1:0] ChSgr     = 8'h6D;  // 'm'
  localparam logic [ByteW-1:0] ChZero    = 8'h30;  // '0'
  localparam logic [ByteW-1:0] ChNine    = 8'h39;  // '9'

  localparam logic [ParamW-1:0] ParamClear = 16'd2;
  localparam logic [ParamW-1:0] ParamBack  = 16'd40;
  localparam logic [ParamW-1:0] ParamMax   = 16'hFFFF;

  localparam logic [RowW-1:0] HeightReset = 8'd25;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ESC     = 3'd1,
    PH_BRACKET = 3'd2,
    PH_PARAM   = 3'd3,
    PH_ERROR   = 3'd4
  } phase_e;

  typedef enum logic [EventW-1:0] {
    EV_TEXT  = 3'd0,
    EV_BUSY  = 3'd1,
    EV_DOWN  = 3'd2,
    EV_HOME  = 3'd3,
    EV_BACK  = 3'd4,
    EV_ERROR = 3'd5
  } event_e;

  // Architectural state of the parser.
  typedef struct packed {
    phase_e              phase;
    logic [ParamW-1:0]   accum;
    logic [RowW-1:0]     row;
  } pstate_t;

endpackage

>>> sv/csi_escape_sequence_parser.sv
// CSI escape sequence parser top level: state, config register, output register.
//
// Parses byte streams of the form ESC '[' digits final, one byte per
// transaction, and answers every accepted byte with exactly one result
// transaction: an event code (0 text, 1 in progress, 2 cursor down, 3 clear
// home, 4 background set, 5 error), the cursor row after the byte, and the
// accumulated parameter. Throughput is one byte per cycle: the whole update
// is a single pass of logic from the parser state to the output register,
// and a new byte is taken whenever the output register is empty or is being
// drained in the same cycle. Its result appears in the cycle after the byte.
// An error is sticky until rst_ni. The screen_height register (reset 25)
// is written through the cfg channel, which is always ready; write it only
// while no result is pending.
module csi_escape_sequence_parser import csi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // byte input
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ByteW-1:0]  in_byte_i,
  // result output
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [EventW-1:0] event_res_o,
  output logic [RowW-1:0]   cursor_row_o,
  output logic [ParamW-1:0] param_value_o,
  // screen_height write
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [RowW-1:0]   cfg_data_i
);

  pstate_t           state_q, state_d;
  logic [RowW-1:0]   height_q;
  event_e            event_d;
  logic              in_fire;

  logic              out_valid_q;
  logic [EventW-1:0] event_q;
  logic [RowW-1:0]   row_q;
  logic [ParamW-1:0] param_q;

  // Output register frees up in the same cycle it is drained.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  csi_step u_step (
    .cur_i    (state_q),
    .height_i (height_q),
    .byte_i   (in_byte_i),
    .nxt_o    (state_d),
    .event_o  (event_d)
  );

  // parser state and config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase <= PH_IDLE;
      state_q.accum <= '0;
      state_q.row   <= '0;
      height_q      <= HeightReset;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (cfg_valid_i) begin
        height_q <= cfg_data_i;
      end
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, loaded with the state after this byte
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      event_q <= event_d;
      row_q   <= state_d.row;
      param_q <= state_d.accum;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_res_o   = event_q;
  assign cursor_row_o  = row_q;
  assign param_value_o = param_q;

endmodule

>>> sv/csi_step.sv
// Next-state and event logic for one input byte.
module csi_step import csi_pkg::*; (
  input  pstate_t          cur_i,
  input  logic [RowW-1:0]  height_i,
  input  logic [ByteW-1:0] byte_i,
  output pstate_t          nxt_o,
  output event_e           event_o
);

  logic                is_digit;
  logic [3:0]          digit;
  logic [ParamW+3:0]   acc_ext;
  logic [ParamW-1:0]   acc_sat;
  logic [RowW-1:0]     bottom;
  logic [ParamW:0]     row_sum;
  logic [RowW-1:0]     row_down;
  logic                is_clear;
  logic                is_back;

  assign is_digit = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign digit    = 4'(byte_i - ChZero);

  // accum * 10 + digit as shifts and adds, saturating at 16 bits
  assign acc_ext = ({4'd0, cur_i.accum} << 3) + ({4'd0, cur_i.accum} << 1)
                 + {16'd0, digit};
  assign acc_sat = (acc_ext > {4'd0, ParamMax}) ? ParamMax : acc_ext[ParamW-1:0];

  // zero height behaves as one row
  assign bottom   = (height_i == '0) ? '0 : height_i - 1'b1;
  assign row_sum  = {{(ParamW+1-RowW){1'b0}}, cur_i.row} + {1'b0, cur_i.accum};
  assign row_down = (row_sum > {{(ParamW+1-RowW){1'b0}}, bottom}) ?
                    bottom : row_sum[RowW-1:0];

  assign is_clear = (byte_i == ChClear) && (cur_i.accum == ParamClear);
  assign is_back  = (byte_i == ChSgr) && (cur_i.accum == ParamBack);

  // next state
  always_comb begin
    nxt_o = cur_i;
    unique case (cur_i.phase)
      PH_IDLE: begin
        if (byte_i == ChEsc) begin
          nxt_o.phase = PH_ESC;
          nxt_o.accum = '0;
        end
      end
      PH_ESC: begin
        nxt_o.phase = (byte_i == ChBracket) ? PH_BRACKET : PH_ERROR;
      end
      PH_BRACKET: begin
        if (is_digit) begin
          nxt_o.phase = PH_PARAM;
          nxt_o.accum = {12'd0, digit};
        end else begin
          nxt_o.phase = PH_ERROR;
        end
      end
      PH_PARAM: begin
        priority if (is_digit) begin
          nxt_o.accum = acc_sat;
        end else if (byte_i == ChDown) begin
          nxt_o.row   = row_down;
          nxt_o.phase = PH_IDLE;
        end else if (is_clear) begin
          nxt_o.row   = '0;
          nxt_o.phase = PH_IDLE;
        end else if (is_back) begin
          nxt_o.phase = PH_IDLE;
        end else begin
          nxt_o.phase = PH_ERROR;
        end
      end
      default: nxt_o.phase = PH_ERROR;
    endcase
  end

  // event code
  always_comb begin
    event_o = EV_ERROR;
    unique case (cur_i.phase)
      PH_IDLE:    event_o = (byte_i == ChEsc) ? EV_BUSY : EV_TEXT;
      PH_ESC:     event_o = (byte_i == ChBracket) ? EV_BUSY : EV_ERROR;
      PH_BRACKET: event_o = is_digit ? EV_BUSY : EV_ERROR;
      PH_PARAM: begin
        priority if (is_digit)             event_o = EV_BUSY;
        else if (byte_i == ChDown)         event_o = EV_DOWN;
        else if (is_clear)                 event_o = EV_HOME;
        else if (is_back)                  event_o = EV_BACK;
        else                               event_o = EV_ERROR;
      end
      default: event_o = EV_ERROR;
    endcase
  end

endmodule

>>> sv/csi_checker.sv
// Port-level checks for the CSI parser, bound to the top level.
`include "csi_escape_sequence_parser_macros.svh"

module csi_checker import csi_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [EventW-1:0] event_res_o,
  input logic [RowW-1:0]   cursor_row_o,
  input logic [ParamW-1:0] param_value_o
);

  logic err_seen_q;

  // set once an error result has been delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_seen_q <= 1'b0;
    end else if (out_valid_o && out_ready_i && (event_res_o == EV_ERROR)) begin
      err_seen_q <= 1'b1;
    end
  end

  `CSI_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(event_res_o) && $stable(cursor_row_o) && $stable(param_value_o))
  `CSI_ASSERT_NOW(a_ready_when_empty, !out_valid_o, in_ready_o)
  `CSI_ASSERT_NOW(a_home_row_zero, out_valid_o && (event_res_o == EV_HOME), cursor_row_o == '0)
  `CSI_ASSERT_NOW(a_error_sticky, out_valid_o && err_seen_q, event_res_o == EV_ERROR)

endmodule

bind csi_escape_sequence_parser csi_checker u_csi_checker (.*);
